[rtl/assert_macros.svh]
// Assertion helpers for the RTL. The checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/cacs_pkg.sv]
package cacs_pkg;

    localparam int MAX_CORES    = 16;
    localparam int MAX_CLUSTERS = 8;

    localparam int IDX_W    = $clog2(MAX_CORES);
    localparam int TOT_W    = $clog2(MAX_CORES + 1);
    localparam int CL_W     = 4;
    localparam int CORE_W   = 8;
    localparam int REQ_W    = 5;
    localparam int OUT_W    = 2;
    localparam int CMP_W    = (TOT_W > REQ_W) ? TOT_W : REQ_W;
    localparam int CL_IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    localparam logic [REQ_W-1:0] REQ_RESET    = 5'd4;
    localparam logic [REQ_W-1:0] RESULT_LIMIT = 5'd16;

    // outcome codes
    localparam logic [OUT_W-1:0] OUT_SINGLE   = 2'd0;
    localparam logic [OUT_W-1:0] OUT_CROSS    = 2'd1;
    localparam logic [OUT_W-1:0] OUT_REJECT   = 2'd2;
    localparam logic [OUT_W-1:0] OUT_OVERFLOW = 2'd3;

    // microcode: datapath ops
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd2;
    localparam logic [OP_W-1:0] OP_PICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN  = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;
    localparam logic [OP_W-1:0] OP_FAIL  = 3'd7;

    // microcode: jump conditions
    localparam int CD_W = 3;
    localparam logic [CD_W-1:0] CD_ALWAYS    = 3'd0;
    localparam logic [CD_W-1:0] CD_END_ACC   = 3'd1;
    localparam logic [CD_W-1:0] CD_CHK_FAIL  = 3'd2;
    localparam logic [CD_W-1:0] CD_SCAN_LAST = 3'd3;
    localparam logic [CD_W-1:0] CD_NO_ANY    = 3'd4;
    localparam logic [CD_W-1:0] CD_EMIT_MORE = 3'd5;
    localparam logic [CD_W-1:0] CD_SLOT_FREE = 3'd6;

    // microcode: what happens when the condition is false
    localparam int EL_W = 2;
    localparam logic [EL_W-1:0] EL_NEXT      = 2'd0;
    localparam logic [EL_W-1:0] EL_STAY      = 2'd1;
    localparam logic [EL_W-1:0] EL_FREE_NEXT = 2'd2;

    // step addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] S_LOAD  = 3'd0;
    localparam logic [PC_W-1:0] S_CHECK = 3'd1;
    localparam logic [PC_W-1:0] S_COUNT = 3'd2;
    localparam logic [PC_W-1:0] S_PICK  = 3'd3;
    localparam logic [PC_W-1:0] S_SCAN  = 3'd4;
    localparam logic [PC_W-1:0] S_EMIT  = 3'd5;
    localparam logic [PC_W-1:0] S_END   = 3'd6;
    localparam logic [PC_W-1:0] S_FAIL  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CD_W-1:0] cond;
        logic [PC_W-1:0] target;
        logic [EL_W-1:0] els;
    } t_ctrl;

    // control store
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl cw;
        case (pc)
            S_LOAD:  cw = '{OP_LOAD,  CD_END_ACC,   S_CHECK, EL_STAY};
            S_CHECK: cw = '{OP_CHECK, CD_CHK_FAIL,  S_FAIL,  EL_NEXT};
            S_COUNT: cw = '{OP_COUNT, CD_SCAN_LAST, S_PICK,  EL_STAY};
            S_PICK:  cw = '{OP_PICK,  CD_NO_ANY,    S_FAIL,  EL_NEXT};
            S_SCAN:  cw = '{OP_SCAN,  CD_SCAN_LAST, S_EMIT,  EL_STAY};
            S_EMIT:  cw = '{OP_EMIT,  CD_EMIT_MORE, S_SCAN,  EL_FREE_NEXT};
            S_END:   cw = '{OP_CLEAR, CD_ALWAYS,    S_LOAD,  EL_NEXT};
            S_FAIL:  cw = '{OP_FAIL,  CD_SLOT_FREE, S_END,   EL_STAY};
            default: cw = '{OP_CLEAR, CD_ALWAYS,    S_LOAD,  EL_NEXT};
        endcase
        return cw;
    endfunction

    // cluster number names a real cluster
    function automatic logic in_range(input logic signed [CL_W-1:0] cl);
        logic ok;
        ok = !cl[CL_W-1] && ((CL_W+1)'($unsigned(cl)) < (CL_W+1)'(MAX_CLUSTERS));
        return ok;
    endfunction

endpackage

[rtl/cluster_affine_core_selector.sv]
// Cluster-affine core selector.
// Input channel (i_in_valid / o_in_stall): one word per core entry, carrying
// cluster number (-1 = none), core number and set_end on the last entry.
// Output channel (o_out_valid / i_out_stall): one word per chosen core, in
// ascending core order, or a single rejection word (outcome 2, or 3 when the
// list overflowed the 16-entry store). final_pick marks the last word.
// Config: i_cfg_we / i_cfg_data write requested_count (reset 4); write only
// while idle.
// Timing: entries load one per cycle while the sequencer is idle. After the
// set-ending word a small microcoded sequencer runs: a check step, count
// steps over the entries, a pick step, then per result scan steps over the
// entries and an emit step, then a cleanup step. A set rejected by the check
// goes straight to the failure step; a set with no entry in any cluster is
// rejected after the count. Input is stalled while the sequencer runs.
// A result sits in an output register; while the receiver stalls it holds,
// and the emit step waits for the slot.
// Reset (synchronous, active low) empties the store, drops the output valid and
// sets requested_count back to 4.
`include "assert_macros.svh"

module cluster_affine_core_selector
    import cacs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [REQ_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [CL_W-1:0]   i_cluster_num,
    input  logic [CORE_W-1:0]        i_core_num,
    input  logic                     i_set_end,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CORE_W-1:0]        o_chosen_core,
    output logic [OUT_W-1:0]         o_outcome,
    output logic                     o_final_pick
);

    // sequencer
    logic [PC_W-1:0]   r_pc, n_pc;
    t_ctrl             cw;
    logic              cond_true;

    // config
    logic [REQ_W-1:0]  r_req;

    // entry store
    logic signed [CL_W-1:0] r_ent_cluster [MAX_CORES];
    logic [CORE_W-1:0]      r_ent_core    [MAX_CORES];
    logic [TOT_W-1:0]       r_total;
    logic                   r_overflow;

    // per-cluster counters
    logic [TOT_W-1:0]  r_count [MAX_CLUSTERS];

    // scan datapath
    logic [IDX_W-1:0]     r_idx;
    logic [MAX_CORES-1:0] r_used;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [CORE_W-1:0]    r_best_core;
    logic                 r_all;
    logic [CL_IDX_W-1:0]  r_sel;
    logic [REQ_W-1:0]     r_k;
    logic [OUT_W-1:0]     r_fail_code;

    // output register
    logic                 r_out_valid;
    logic [CORE_W-1:0]    r_out_core;
    logic [OUT_W-1:0]     r_out_outcome;
    logic                 r_out_final;

    // decode helpers
    logic                    in_acc;
    logic                    slot_free;
    logic                    scan_last;
    logic                    chk_fail;
    logic                    emit_last;
    logic signed [CL_W-1:0]  cur_cl;
    logic [CORE_W-1:0]       cur_core;
    logic                    eligible;
    logic                    pick_hit;
    logic                    pick_any;
    logic [CL_IDX_W-1:0]     pick_idx;

    assign cw        = ucode(r_pc);
    assign o_in_stall = (r_pc != S_LOAD);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign cur_cl    = r_ent_cluster[r_idx];
    assign cur_core  = r_ent_core[r_idx];
    assign scan_last = ((TOT_W)'(r_idx) + (TOT_W)'(1)) == r_total;
    assign emit_last = (r_k + (REQ_W)'(1)) == r_req;

    assign chk_fail = r_overflow || (r_req == '0)
                   || ((CMP_W)'(r_req) > (CMP_W)'(r_total))
                   || (r_req > RESULT_LIMIT);

    assign eligible = !r_used[r_idx]
                   && (r_all || (in_range(cur_cl) && (cur_cl[CL_IDX_W-1:0] == r_sel)));

    // highest cluster holding enough cores; later hits overwrite earlier ones
    always_comb begin
        pick_hit = 1'b0;
        pick_any = 1'b0;
        pick_idx = '0;
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
            if (r_count[c] != '0) begin
                pick_any = 1'b1;
            end
            if ((CMP_W)'(r_count[c]) >= (CMP_W)'(r_req)) begin
                pick_hit = 1'b1;
                pick_idx = (CL_IDX_W)'(c);
            end
        end
    end

    // jump condition
    always_comb begin
        case (cw.cond)
            CD_ALWAYS:    cond_true = 1'b1;
            CD_END_ACC:   cond_true = in_acc && i_set_end;
            CD_CHK_FAIL:  cond_true = chk_fail;
            CD_SCAN_LAST: cond_true = scan_last;
            CD_NO_ANY:    cond_true = !pick_any;
            CD_EMIT_MORE: cond_true = slot_free && !emit_last;
            CD_SLOT_FREE: cond_true = slot_free;
            default:      cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (cond_true) begin
            n_pc = cw.target;
        end else begin
            case (cw.els)
                EL_NEXT:      n_pc = r_pc + (PC_W)'(1);
                EL_STAY:      n_pc = r_pc;
                EL_FREE_NEXT: n_pc = slot_free ? r_pc + (PC_W)'(1) : r_pc;
                default:      n_pc = r_pc;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_LOAD;
            r_req       <= REQ_RESET;
            r_total     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                r_req <= i_cfg_data;
            end

            if (cw.op == OP_LOAD && in_acc) begin
                if (r_total < (TOT_W)'(MAX_CORES)) begin
                    r_total <= r_total + (TOT_W)'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (cw.op == OP_CLEAR) begin
                r_total    <= '0;
                r_overflow <= 1'b0;
            end

            if ((cw.op == OP_EMIT || cw.op == OP_FAIL) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (cw.op)
            OP_LOAD: begin
                if (in_acc && r_total < (TOT_W)'(MAX_CORES)) begin
                    r_ent_cluster[r_total[IDX_W-1:0]] <= i_cluster_num;
                    r_ent_core[r_total[IDX_W-1:0]]    <= i_core_num;
                end
            end
            OP_CHECK: begin
                r_fail_code <= r_overflow ? OUT_OVERFLOW : OUT_REJECT;
                r_idx       <= '0;
                for (int c = 0; c < MAX_CLUSTERS; c++) begin
                    r_count[c] <= '0;
                end
            end
            OP_COUNT: begin
                if (in_range(cur_cl)) begin
                    r_count[cur_cl[CL_IDX_W-1:0]] <= r_count[cur_cl[CL_IDX_W-1:0]]
                                                   + (TOT_W)'(1);
                end
                r_idx <= r_idx + (IDX_W)'(1);
            end
            OP_PICK: begin
                r_all   <= !pick_hit;
                r_sel   <= pick_idx;
                r_used  <= '0;
                r_k     <= '0;
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            OP_SCAN: begin
                if (eligible && (!r_found || cur_core < r_best_core)) begin
                    r_found     <= 1'b1;
                    r_best_idx  <= r_idx;
                    r_best_core <= cur_core;
                end
                r_idx <= r_idx + (IDX_W)'(1);
            end
            OP_EMIT: begin
                if (slot_free) begin
                    r_out_core    <= r_best_core;
                    r_out_outcome <= r_all ? OUT_CROSS : OUT_SINGLE;
                    r_out_final   <= emit_last;
                    r_used[r_best_idx] <= 1'b1;
                    r_k     <= r_k + (REQ_W)'(1);
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
            end
            OP_FAIL: begin
                if (slot_free) begin
                    r_out_core    <= '0;
                    r_out_outcome <= r_fail_code;
                    r_out_final   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_chosen_core = r_out_core;
    assign o_outcome     = r_out_outcome;
    assign o_final_pick  = r_out_final;

    // checks
    `ASSERT_IMPLY(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= (TOT_W)'(MAX_CORES))
    `ASSERT_IMPLY(a_emit_has_pick, i_clk, i_rst_n, r_pc == S_EMIT, r_found)
    `ASSERT_NEXT(a_last_to_end, i_clk, i_rst_n, r_pc == S_EMIT && slot_free && emit_last, r_pc == S_END)
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, r_pc == S_END, r_total == '0 && !r_overflow && r_pc == S_LOAD)

endmodule
